/* hdl/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // isqrt datapath, Q30 squared fits in 62 bits
  localparam int RW         = 62;
  localparam int SQRT_STEPS = 31;

  // clamped arcsine argument, Q30
  localparam int TW = 32;

  // angle accumulator, Q30 radians
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [15:0]          PI_Q12      = 16'd12868;
  localparam logic [15:0]          HALF_PI_Q12 = 16'd6434;

  // atan(2^-i) in Q30 radians
  function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:    return 32'sd843314857;
      5'd1:    return 32'sd497837830;
      5'd2:    return 32'sd263043837;
      5'd3:    return 32'sd133525159;
      5'd4:    return 32'sd67021687;
      5'd5:    return 32'sd33543516;
      5'd6:    return 32'sd16775851;
      5'd7:    return 32'sd8388437;
      5'd8:    return 32'sd4194283;
      5'd9:    return 32'sd2097149;
      5'd10:   return 32'sd1048576;
      5'd11:   return 32'sd524288;
      5'd12:   return 32'sd262144;
      5'd13:   return 32'sd131072;
      5'd14:   return 32'sd65536;
      5'd15:   return 32'sd32768;
      5'd16:   return 32'sd16384;
      5'd17:   return 32'sd8192;
      5'd18:   return 32'sd4096;
      5'd19:   return 32'sd2048;
      5'd20:   return 32'sd1024;
      5'd21:   return 32'sd512;
      5'd22:   return 32'sd256;
      5'd23:   return 32'sd128;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hdl/q2e_front.sv */
// ----------------------------------------------------------------------------
// q2e_front
// Five-stage front end: component products, direction-cosine terms, Q30
// rescale with arcsine saturation, and the radicand 1 - t*t for the isqrt.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_front #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int MW             = 35,
  parameter int QW             = 37
) (
  input  wire logic                          clk,
  input  wire logic [4:0]                    en,
  input  wire logic signed [15:0]            q_w,
  input  wire logic signed [15:0]            q_x,
  input  wire logic signed [15:0]            q_y,
  input  wire logic signed [15:0]            q_z,
  output logic signed [QW-1:0]               yaw_x_o,
  output logic signed [QW-1:0]               yaw_y_o,
  output logic signed [QW-1:0]               roll_x_o,
  output logic signed [QW-1:0]               roll_y_o,
  output logic signed [q2e_pkg::TW-1:0]      t_o,
  output logic                               clamp_o,
  output logic [q2e_pkg::RW-1:0]             rad_o
);
  import q2e_pkg::*;

  localparam int SHR = (2*QUAT_FRAC_BITS > 30) ? 2*QUAT_FRAC_BITS - 30 : 0;
  localparam int SHL = (2*QUAT_FRAC_BITS < 30) ? 30 - 2*QUAT_FRAC_BITS : 0;
  localparam int RSH = (SHR > 0) ? SHR - 1 : 0;
  localparam logic signed [MW-1:0] ONE      = MW'(1) << (2*QUAT_FRAC_BITS);
  localparam logic [MW-1:0]        HALF_LSB = MW'(1) << RSH;
  localparam logic signed [QW-1:0] Q30_ONE  = QW'(1) << 30;

  // rescale to Q30, round half away from zero
  function automatic logic signed [QW-1:0] to_q30(input logic signed [MW-1:0] v);
    logic [MW-1:0] mag;
    logic [MW-1:0] rnd;
    mag = v[MW-1] ? MW'(-v) : MW'(v);
    rnd = (mag + HALF_LSB) >> SHR;
    if (SHR > 0) begin
      if (v[MW-1]) begin
        return -QW'($signed(rnd));
      end
      return QW'($signed(rnd));
    end
    return QW'(v) <<< SHL;
  endfunction

  // stage 1: products
  logic signed [31:0] pww_r, pxx_r, pzz_r, pxy_r, pwz_r, pxz_r, pwy_r, pyz_r, pwx_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pww_r <= q_w * q_w;
      pxx_r <= q_x * q_x;
      pzz_r <= q_z * q_z;
      pxy_r <= q_x * q_y;
      pwz_r <= q_w * q_z;
      pxz_r <= q_x * q_z;
      pwy_r <= q_w * q_y;
      pyz_r <= q_y * q_z;
      pwx_r <= q_w * q_x;
    end
  end

  // stage 2: matrix terms
  logic signed [MW-1:0] m11_r, m12_r, m13_r, m23_r, m33_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m11_r <= ((MW'(pww_r) + MW'(pxx_r)) <<< 1) - ONE;
      m12_r <= (MW'(pxy_r) + MW'(pwz_r)) <<< 1;
      m13_r <= (MW'(pxz_r) - MW'(pwy_r)) <<< 1;
      m23_r <= (MW'(pyz_r) + MW'(pwx_r)) <<< 1;
      m33_r <= ((MW'(pww_r) + MW'(pzz_r)) <<< 1) - ONE;
    end
  end

  // stage 3: saturate arcsine argument, rescale
  logic signed [MW-1:0] s_neg, s_sat;
  logic                 cl_nxt;
  logic signed [QW-1:0] t_q;
  logic signed [TW-1:0] t_nxt;

  always_comb begin
    s_neg  = -m13_r;
    s_sat  = s_neg;
    cl_nxt = 1'b0;
    if (s_neg > ONE) begin
      s_sat  = ONE;
      cl_nxt = 1'b1;
    end else if (s_neg < -ONE) begin
      s_sat  = -ONE;
      cl_nxt = 1'b1;
    end
    t_q = to_q30(s_sat);
    if (t_q > Q30_ONE) begin
      t_q = Q30_ONE;
    end else if (t_q < -Q30_ONE) begin
      t_q = -Q30_ONE;
    end
    t_nxt = TW'(t_q);
  end

  logic signed [QW-1:0] yx3_r, yy3_r, rx3_r, ry3_r;
  logic signed [TW-1:0] t3_r;
  logic                 cl3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      yx3_r <= to_q30(m11_r);
      yy3_r <= to_q30(m12_r);
      rx3_r <= to_q30(m33_r);
      ry3_r <= to_q30(m23_r);
      t3_r  <= t_nxt;
      cl3_r <= cl_nxt;
    end
  end

  // stage 4: partial products of t*t
  logic [TW-1:0] t_mag;
  logic [14:0]   t_hi;
  logic [15:0]   t_lo;

  always_comb begin
    t_mag = t3_r[TW-1] ? TW'(-t3_r) : TW'(t3_r);
    t_hi  = t_mag[30:16];
    t_lo  = t_mag[15:0];
  end

  logic signed [QW-1:0] yx4_r, yy4_r, rx4_r, ry4_r;
  logic signed [TW-1:0] t4_r;
  logic                 cl4_r;
  logic [29:0]          phh_r;
  logic [30:0]          phl_r;
  logic [31:0]          pll_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      yx4_r <= yx3_r;
      yy4_r <= yy3_r;
      rx4_r <= rx3_r;
      ry4_r <= ry3_r;
      t4_r  <= t3_r;
      cl4_r <= cl3_r;
      phh_r <= t_hi * t_hi;
      phl_r <= 31'(t_hi * t_lo);
      pll_r <= t_lo * t_lo;
    end
  end

  // stage 5: radicand
  logic [RW-1:0] sq_sum;

  always_comb begin
    sq_sum = (RW'(phh_r) << 32) + (RW'(phl_r) << 17) + RW'(pll_r);
  end

  logic signed [QW-1:0] yx5_r, yy5_r, rx5_r, ry5_r;
  logic signed [TW-1:0] t5_r;
  logic                 cl5_r;
  logic [RW-1:0]        rad_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      yx5_r <= yx4_r;
      yy5_r <= yy4_r;
      rx5_r <= rx4_r;
      ry5_r <= ry4_r;
      t5_r  <= t4_r;
      cl5_r <= cl4_r;
      rad_r <= (RW'(1) << 60) - sq_sum;
    end
  end

  assign yaw_x_o  = yx5_r;
  assign yaw_y_o  = yy5_r;
  assign roll_x_o = rx5_r;
  assign roll_y_o = ry5_r;
  assign t_o      = t5_r;
  assign clamp_o  = cl5_r;
  assign rad_o    = rad_r;

endmodule

`default_nettype wire

/* hdl/q2e_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit of the integer square root: trial subtract, one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell #(
  parameter int STEP = 0,
  parameter int SBW  = 1
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [q2e_pkg::RW-1:0]    rem_i,
  input  wire logic [q2e_pkg::RW-1:0]    root_i,
  input  wire logic [SBW-1:0]            sb_i,
  output logic [q2e_pkg::RW-1:0]         rem_o,
  output logic [q2e_pkg::RW-1:0]         root_o,
  output logic [SBW-1:0]                 sb_o
);
  import q2e_pkg::*;

  localparam logic [RW-1:0] BIT = RW'(1) << (2*(SQRT_STEPS - 1 - STEP));

  logic [RW-1:0] trial, rem_nxt, root_nxt;
  logic [RW-1:0] rem_r, root_r;
  logic [SBW-1:0] sb_r;

  always_comb begin
    trial = root_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt  = rem_i - trial;
      root_nxt = (root_i >> 1) + BIT;
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      sb_r   <= sb_i;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign sb_o   = sb_r;

endmodule

`default_nettype wire

/* hdl/q2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One CORDIC vectoring micro-rotation, drives y toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
  parameter int CW  = 40,
  parameter int IDX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [CW-1:0]          x_i,
  input  wire logic signed [CW-1:0]          y_i,
  input  wire logic signed [q2e_pkg::ZW-1:0] z_i,
  input  wire logic                          zero_i,
  output logic signed [CW-1:0]               x_o,
  output logic signed [CW-1:0]               y_o,
  output logic signed [q2e_pkg::ZW-1:0]      z_o,
  output logic                               zero_o
);
  import q2e_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(5'(IDX)));

  logic signed [CW-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic                 zero_r;

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (y_i > 0) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign zero_o = zero_r;

endmodule

`default_nettype wire

/* hdl/quaternion_to_euler_angles.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Quaternion (Q1.14) to ZYX Euler angles (Q12 radians), fully pipelined.
// ----------------------------------------------------------------------------
// One quaternion is taken every cycle unless back-pressure from out_ready fills
// the pipe, and each gives one word of roll, pitch and yaw, in order. From input
// to output register a word passes five front stages for products, matrix terms
// and the radicand, 31 square-root cells, one quadrant pre-rotation stage, the
// CORDIC stages, each with three cells for the three angles in parallel, and the
// output rounding register. Every stage stalls on its own, so bubbles are squeezed
// out and new words are taken while a finished word waits on out_ready. The
// quaternion is not normalized; pitch_clamped flags a saturated arcsine input.
`default_nettype none

module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES  = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int QUAT_FRAC_BITS = q2e_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_q_w,
  input  wire logic signed [15:0] in_q_x,
  input  wire logic signed [15:0] in_q_y,
  input  wire logic signed [15:0] in_q_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [14:0]      out_roll,
  output logic signed [13:0]      out_pitch,
  output logic signed [14:0]      out_yaw,
  output logic                    out_pitch_clamped
);
  import q2e_pkg::*;

  localparam int MW     = ((2*QUAT_FRAC_BITS + 2) > 34 ? 2*QUAT_FRAC_BITS + 2 : 34) + 1;
  localparam int SHL    = (2*QUAT_FRAC_BITS < 30) ? 30 - 2*QUAT_FRAC_BITS : 0;
  localparam int QW     = MW + SHL;
  localparam int CW     = QW + 3;
  localparam int SBW    = TW + 1 + 4*QW;
  localparam int ST_SQ  = 5;
  localparam int ST_PRE = ST_SQ + SQRT_STEPS;
  localparam int ST_COR = ST_PRE + 1;
  localparam int ST_OUT = ST_COR + CORDIC_STAGES;
  localparam int NST    = ST_OUT + 1;

  // elastic handshake, one valid per stage
  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST:0]   rdy;

  assign rdy[NST] = out_ready;

  genvar gi;
  generate
    for (gi = 0; gi < NST; gi++) begin : g_rdy
      assign rdy[gi] = ~vld_r[gi] | rdy[gi+1];
    end
  endgenerate

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NST; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NST-1];

  // front end
  logic signed [QW-1:0] f_yaw_x, f_yaw_y, f_roll_x, f_roll_y;
  logic signed [TW-1:0] f_t;
  logic                 f_clamp;
  logic [RW-1:0]        f_rad;

  q2e_front #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .MW             (MW),
    .QW             (QW)
  ) u_front (
    .clk      (clk),
    .en       (rdy[4:0]),
    .q_w      (in_q_w),
    .q_x      (in_q_x),
    .q_y      (in_q_y),
    .q_z      (in_q_z),
    .yaw_x_o  (f_yaw_x),
    .yaw_y_o  (f_yaw_y),
    .roll_x_o (f_roll_x),
    .roll_y_o (f_roll_y),
    .t_o      (f_t),
    .clamp_o  (f_clamp),
    .rad_o    (f_rad)
  );

  // square-root chain, atan2 operands ride along
  logic [RW-1:0]  sq_rem  [0:SQRT_STEPS-1];
  logic [RW-1:0]  sq_root [0:SQRT_STEPS];
  logic [SBW-1:0] sq_sb   [0:SQRT_STEPS];

  assign sq_rem[0]  = f_rad;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = {f_t, f_clamp, f_roll_y, f_roll_x, f_yaw_y, f_yaw_x};

  generate
    for (gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
      if (gi == SQRT_STEPS - 1) begin : g_last
        q2e_sqrt_cell #(.STEP(gi), .SBW(SBW)) u_cell (
          .clk    (clk),
          .en     (rdy[ST_SQ+gi]),
          .rem_i  (sq_rem[gi]),
          .root_i (sq_root[gi]),
          .sb_i   (sq_sb[gi]),
          .rem_o  (),
          .root_o (sq_root[gi+1]),
          .sb_o   (sq_sb[gi+1])
        );
      end else begin : g_mid
        q2e_sqrt_cell #(.STEP(gi), .SBW(SBW)) u_cell (
          .clk    (clk),
          .en     (rdy[ST_SQ+gi]),
          .rem_i  (sq_rem[gi]),
          .root_i (sq_root[gi]),
          .sb_i   (sq_sb[gi]),
          .rem_o  (sq_rem[gi+1]),
          .root_o (sq_root[gi+1]),
          .sb_o   (sq_sb[gi+1])
        );
      end
    end
  endgenerate

  // vectors: 0 roll, 1 pitch, 2 yaw
  logic [SBW-1:0]       sb_end;
  logic signed [CW-1:0] vin_x [0:2];
  logic signed [CW-1:0] vin_y [0:2];

  always_comb begin
    sb_end   = sq_sb[SQRT_STEPS];
    vin_x[2] = CW'($signed(sb_end[QW-1:0]));
    vin_y[2] = CW'($signed(sb_end[2*QW-1:QW]));
    vin_x[0] = CW'($signed(sb_end[3*QW-1:2*QW]));
    vin_y[0] = CW'($signed(sb_end[4*QW-1:3*QW]));
    vin_x[1] = CW'($signed({1'b0, sq_root[SQRT_STEPS][30:0]}));
    vin_y[1] = CW'($signed(sb_end[4*QW+TW:4*QW+1]));
  end

  // quadrant pre-rotation into the right half plane
  logic signed [CW-1:0] pre_x_nxt [0:2];
  logic signed [CW-1:0] pre_y_nxt [0:2];
  logic signed [ZW-1:0] pre_z_nxt [0:2];
  logic                 pre_zero_nxt [0:2];
  logic signed [CW-1:0] pre_x_r [0:2];
  logic signed [CW-1:0] pre_y_r [0:2];
  logic signed [ZW-1:0] pre_z_r [0:2];
  logic                 pre_zero_r [0:2];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      pre_zero_nxt[v] = (vin_x[v] == '0) && (vin_y[v] == '0);
      pre_x_nxt[v]    = vin_x[v];
      pre_y_nxt[v]    = vin_y[v];
      pre_z_nxt[v]    = '0;
      if (vin_x[v] < 0) begin
        if (vin_y[v] >= 0) begin
          pre_x_nxt[v] = vin_y[v];
          pre_y_nxt[v] = -vin_x[v];
          pre_z_nxt[v] = HALF_PI_Q30;
        end else begin
          pre_x_nxt[v] = -vin_y[v];
          pre_y_nxt[v] = vin_x[v];
          pre_z_nxt[v] = -HALF_PI_Q30;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PRE]) begin
      for (int v = 0; v < 3; v++) begin
        pre_x_r[v]    <= pre_x_nxt[v];
        pre_y_r[v]    <= pre_y_nxt[v];
        pre_z_r[v]    <= pre_z_nxt[v];
        pre_zero_r[v] <= pre_zero_nxt[v];
      end
    end
  end

  // CORDIC rows, three cells per stage
  logic signed [CW-1:0] cx [0:CORDIC_STAGES][0:2];
  logic signed [CW-1:0] cy [0:CORDIC_STAGES][0:2];
  logic signed [ZW-1:0] cz [0:CORDIC_STAGES][0:2];
  logic                 cn [0:CORDIC_STAGES][0:2];

  genvar gk, gv;
  generate
    for (gv = 0; gv < 3; gv++) begin : g_head
      assign cx[0][gv] = pre_x_r[gv];
      assign cy[0][gv] = pre_y_r[gv];
      assign cz[0][gv] = pre_z_r[gv];
      assign cn[0][gv] = pre_zero_r[gv];
    end
    for (gk = 0; gk < CORDIC_STAGES; gk++) begin : g_cor
      for (gv = 0; gv < 3; gv++) begin : g_vec
        q2e_cordic_cell #(.CW(CW), .IDX(gk)) u_cell (
          .clk    (clk),
          .en     (rdy[ST_COR+gk]),
          .x_i    (cx[gk][gv]),
          .y_i    (cy[gk][gv]),
          .z_i    (cz[gk][gv]),
          .zero_i (cn[gk][gv]),
          .x_o    (cx[gk+1][gv]),
          .y_o    (cy[gk+1][gv]),
          .z_o    (cz[gk+1][gv]),
          .zero_o (cn[gk+1][gv])
        );
      end
    end
  endgenerate

  // saturation flag follows the angle pipe
  logic clp_r [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (rdy[ST_PRE]) begin
      clp_r[0] <= sb_end[4*QW];
    end
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      if (rdy[ST_COR+k]) begin
        clp_r[k+1] <= clp_r[k];
      end
    end
  end

  // Q30 to Q12, half away from zero, then limit
  function automatic logic signed [15:0] angle_q12(input logic signed [ZW-1:0] z,
                                                   input logic zero,
                                                   input logic [15:0] lim);
    logic [ZW-1:0] mag;
    logic [ZW-1:0] rnd;
    logic [15:0]   a;
    mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
    rnd = (mag + (ZW'(1) << 17)) >> 18;
    a   = (rnd > ZW'(lim)) ? lim : rnd[15:0];
    if (zero) begin
      a = '0;
    end
    if (z[ZW-1]) begin
      return -$signed(a);
    end
    return $signed(a);
  endfunction

  logic signed [14:0] roll_r, yaw_r;
  logic signed [13:0] pitch_r;
  logic               clamp_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      roll_r  <= 15'(angle_q12(cz[CORDIC_STAGES][0], cn[CORDIC_STAGES][0], PI_Q12));
      pitch_r <= 14'(angle_q12(cz[CORDIC_STAGES][1], cn[CORDIC_STAGES][1], HALF_PI_Q12));
      yaw_r   <= 15'(angle_q12(cz[CORDIC_STAGES][2], cn[CORDIC_STAGES][2], PI_Q12));
      clamp_r <= clp_r[CORDIC_STAGES];
    end
  end

  assign out_roll          = roll_r;
  assign out_pitch         = pitch_r;
  assign out_yaw           = yaw_r;
  assign out_pitch_clamped = clamp_r;

endmodule

`default_nettype wire

/* dv/tb_quaternion_to_euler_angles.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles
// Drives quaternions through the converter and checks each angle word against
// a bit-exact fixed-point predictor, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_to_euler_angles;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STAGES = q2e_pkg::CORDIC_STAGES_DEF;
  localparam int FRAC_BITS  = q2e_pkg::QUAT_FRAC_BITS_DEF;
  localparam int NUM_RANDOM = 1230;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint Q30_UNIT = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
    logic               clamped;
  } angles_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_q_w, in_q_x, in_q_y, in_q_z;
  logic out_valid;
  logic out_ready;
  logic signed [14:0] out_roll;
  logic signed [13:0] out_pitch;
  logic signed [14:0] out_yaw;
  logic out_pitch_clamped;

  quat_t   pending_quats[$];
  angles_t expected_angles[$];
  int      error_count;
  longint  cycle_count;
  bit      stim_done;
  int      in_gap;
  int      out_stall;

  quaternion_to_euler_angles #(
    .CORDIC_STAGES(NUM_STAGES),
    .QUAT_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_q_w(in_q_w),
    .in_q_x(in_q_x),
    .in_q_y(in_q_y),
    .in_q_z(in_q_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_roll(out_roll),
    .out_pitch(out_pitch),
    .out_yaw(out_yaw),
    .out_pitch_clamped(out_pitch_clamped)
  );

  function automatic longint round_shift(longint v, int k);
    longint mag;
    if (k == 0) return v;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (k - 1))) >>> k;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint rescale_q30(longint v);
    int k;
    k = 2 * FRAC_BITS - 30;
    if (k >= 0) return round_shift(v, k);
    return v * (64'sd1 <<< (-k));
  endfunction

  function automatic longint arctan2_q30(longint yv, longint xv);
    longint acc, tmp, xs, ys;
    logic signed [31:0] step_angle;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      tmp = xv;
      if (yv >= 0) begin
        xv = yv; yv = -tmp; acc = HALF_PI_Q30;
      end else begin
        xv = -yv; yv = tmp; acc = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < NUM_STAGES && i < 24; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      step_angle = q2e_pkg::atan_q30(i[4:0]);
      if (yv > 0) begin
        xv = xv + ys; yv = yv - xs; acc += step_angle;
      end else begin
        xv = xv - ys; yv = yv + xs; acc -= step_angle;
      end
    end
    return acc;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint to_angle(longint acc, longint lim);
    longint a;
    a = round_shift(acc, 18);
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function automatic angles_t predict_angles(quat_t q);
    longint w, x, y, z, one, m11, m12, m13, m23, m33, s, t, c;
    angles_t r;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one = 64'sd1 <<< (2 * FRAC_BITS);
    m11 = 2 * (w * w + x * x) - one;
    m12 = 2 * (x * y + w * z);
    m13 = 2 * (x * z - w * y);
    m23 = 2 * (y * z + w * x);
    m33 = 2 * (w * w + z * z) - one;
    s = -m13;
    r.clamped = 1'b0;
    if (s > one) begin
      s = one; r.clamped = 1'b1;
    end
    if (s < -one) begin
      s = -one; r.clamped = 1'b1;
    end
    t = rescale_q30(s);
    if (t > Q30_UNIT) t = Q30_UNIT;
    if (t < -Q30_UNIT) t = -Q30_UNIT;
    c = int_sqrt(longint'(Q30_UNIT * Q30_UNIT - t * t));
    r.roll  = 15'(to_angle(arctan2_q30(rescale_q30(m23), rescale_q30(m33)), 12868));
    r.pitch = 14'(to_angle(arctan2_q30(t, c), 6434));
    r.yaw   = 15'(to_angle(arctan2_q30(rescale_q30(m12), rescale_q30(m11)), 12868));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 32)) - 16'sd16;
      2: return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
      default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  // mostly near-unit quaternions so pitch spans its range without clamping
  function automatic quat_t rand_quat();
    quat_t q;
    real a, b, c, d, n;
    if ($urandom_range(0, 3) == 0) begin
      q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
      return q;
    end
    a = real'($urandom_range(0, 2000)) - 1000.0;
    b = real'($urandom_range(0, 2000)) - 1000.0;
    c = real'($urandom_range(0, 2000)) - 1000.0;
    d = real'($urandom_range(0, 2000)) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    q.w = 16'($rtoi(a / n * 16383.0));
    q.x = 16'($rtoi(b / n * 16383.0));
    q.y = 16'($rtoi(c / n * 16383.0));
    q.z = 16'($rtoi(d / n * 16383.0));
    return q;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    quat_t q;
    rst_n = 1'b0;
    // directed: identity, axis turns, gimbal lock, zero, extremes, raw patterns
    pending_quats.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    pending_quats.push_back({16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
    pending_quats.push_back({16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
    pending_quats.push_back({16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
    pending_quats.push_back({16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
    pending_quats.push_back({-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
    pending_quats.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_quats.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_quats.push_back({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    pending_quats.push_back({16'sh8000, 16'sh0000, 16'sh7fff, 16'shffff});
    pending_quats.push_back({16'shffff, 16'shffff, 16'shffff, 16'shffff});
    pending_quats.push_back({16'sd16384, 16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, -16'sd16384, 16'sd16384});
    pending_quats.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0});
    for (int i = 0; i < NUM_RANDOM; i++) begin
      q = rand_quat();
      pending_quats.push_back(q);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver, the head of the queue is the word on the bus until accepted
  always @(posedge clk) begin
    quat_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_q_w <= '0; in_q_x <= '0; in_q_y <= '0; in_q_z <= '0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_angles.push_back(predict_angles({in_q_w, in_q_x, in_q_y, in_q_z}));
        void'(pending_quats.pop_front());
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        q = pending_quats[0];
        in_valid <= 1'b1;
        in_q_w <= q.w; in_q_x <= q.x; in_q_y <= q.y; in_q_z <= q.z;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    angles_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_angles.pop_front();
          if (out_roll !== want.roll) report_mismatch("roll", out_roll, want.roll);
          if (out_pitch !== want.pitch) report_mismatch("pitch", out_pitch, want.pitch);
          if (out_yaw !== want.yaw) report_mismatch("yaw", out_yaw, want.yaw);
          if (out_pitch_clamped !== want.clamped)
            report_mismatch("pitch_clamped", out_pitch_clamped, want.clamped);
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall <= pick_gap();
      end
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_q_w = '0; in_q_x = '0; in_q_y = '0; in_q_z = '0;
    fork
      begin
        wait (rst_n);
        while (pending_quats.size() != 0 || expected_angles.size() != 0)
          @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0) begin
          $display("Testbench completed without errors");
        end else begin
          $display("Testbench completed WITH ERRORS");
        end
        $finish;
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    join
  end

endmodule

`default_nettype wire

/* quaternion_to_euler_angles.f */
hdl/q2e_pkg.sv
hdl/q2e_front.sv
hdl/q2e_sqrt_cell.sv
hdl/q2e_cordic_cell.sv
hdl/quaternion_to_euler_angles.sv
dv/tb_quaternion_to_euler_angles.sv
